@@ rtl/tbw_pkg.sv @@
// Shared types and fixed field widths for the barycentric weight pipeline.
// Depends on nothing; imported by triangle_barycentric_weights_top.
package tbw_pkg;

    // Widths fixed by the request and result fields.
    localparam int CORNER_W = 16;
    localparam int PIXEL_W  = 12;
    localparam int WEIGHT_W = 24;

    typedef logic signed [CORNER_W-1:0] corner_t;
    typedef logic        [PIXEL_W-1:0]  pixel_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;

endpackage

@@ rtl/triangle_barycentric_weights_top.sv @@
// Barycentric weight pipeline: corner differences, cross product and two
// pipelined restoring dividers. Depends on tbw_pkg.
//
// Each request carries three triangle corners in signed fixed point and an
// integer pixel position; the block returns the weights (1-u-v, v, u) in
// signed fixed point with WEIGHT_FRAC_BITS fraction bits, each saturated to
// 24 bits, and flags a triangle of zero area with all weights zero. Quotients
// truncate toward zero. One request is taken every clock while the result port
// does not stall. The two dividers resolve one quotient bit per stage, where
// N = R_W + WEIGHT_FRAC_BITS is the dividend width and R_W the cross product
// width. When the result port stalls the whole pipeline holds.
module triangle_barycentric_weights_top #(
    parameter int COORD_FRAC_BITS  = 4,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tbw_pkg::corner_t  corner_a_x,
    input  tbw_pkg::corner_t  corner_a_y,
    input  tbw_pkg::corner_t  corner_b_x,
    input  tbw_pkg::corner_t  corner_b_y,
    input  tbw_pkg::corner_t  corner_c_x,
    input  tbw_pkg::corner_t  corner_c_y,
    input  tbw_pkg::pixel_t   pixel_x,
    input  tbw_pkg::pixel_t   pixel_y,
    output logic              out_valid,
    input  logic              out_ready,
    output tbw_pkg::weight_t  weight_a,
    output tbw_pkg::weight_t  weight_b,
    output tbw_pkg::weight_t  weight_c,
    output logic              degenerate
);
    import tbw_pkg::*;

    // Derived widths.
    localparam int E_W  = CORNER_W + 1;
    localparam int PW   = PIXEL_W + COORD_FRAC_BITS;
    localparam int EZ_W = ((PW > CORNER_W) ? PW : CORNER_W) + 2;
    localparam int P_W  = E_W + EZ_W;
    localparam int R_W  = P_W + 1;
    localparam int N    = R_W + WEIGHT_FRAC_BITS;
    localparam int A_W  = R_W + N;
    localparam int S_W  = N + 3;

    localparam logic signed [S_W-1:0] ONE    = S_W'(1) << WEIGHT_FRAC_BITS;
    localparam logic signed [S_W-1:0] SATMAX = S_W'((1 << (WEIGHT_W - 1)) - 1);
    localparam logic signed [S_W-1:0] SATMIN = -S_W'(1 << (WEIGHT_W - 1));

    // One restoring division step: shift in a bit, subtract if it fits.
    function automatic logic [A_W-1:0] div_step(input logic [A_W-1:0] acc,
                                                input logic [R_W-1:0] d);
        logic [A_W:0]   t;
        logic [R_W:0]   top;
        logic [R_W:0]   diff;
        t    = {acc, 1'b0};
        top  = t[A_W:N];
        diff = top - {1'b0, d};
        if (top >= {1'b0, d})
        begin
            t[A_W:N] = diff;
            t[0]     = 1'b1;
        end
        return t[A_W-1:0];
    endfunction

    // Saturate a wide signed weight to the result width.
    function automatic weight_t sat_w(input logic signed [S_W-1:0] x);
        if (x > SATMAX)
        begin
            return weight_t'(SATMAX);
        end
        else if (x < SATMIN)
        begin
            return weight_t'(SATMIN);
        end
        return weight_t'(x);
    endfunction

    logic advance;

    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    // Stage 1: edge differences.
    logic                  s1_valid_reg;
    logic signed [E_W-1:0]  e1x_reg, e1y_reg, e2x_reg, e2y_reg;
    logic signed [EZ_W-1:0] e1z_reg, e2z_reg;
    logic signed [EZ_W-1:0] px_s, py_s;

    assign px_s = $signed(EZ_W'(PW'(pixel_x) << COORD_FRAC_BITS));
    assign py_s = $signed(EZ_W'(PW'(pixel_y) << COORD_FRAC_BITS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            e1x_reg <= E_W'(corner_c_x) - E_W'(corner_a_x);
            e1y_reg <= E_W'(corner_b_x) - E_W'(corner_a_x);
            e2x_reg <= E_W'(corner_c_y) - E_W'(corner_a_y);
            e2y_reg <= E_W'(corner_b_y) - E_W'(corner_a_y);
            e1z_reg <= EZ_W'(corner_a_x) - px_s;
            e2z_reg <= EZ_W'(corner_a_y) - py_s;
        end
    end

    // Stage 2: the six partial products of the cross product.
    logic                  s2_valid_reg;
    logic signed [P_W-1:0] mx0_reg, mx1_reg, my0_reg, my1_reg, mz0_reg, mz1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mx0_reg <= P_W'(e1y_reg) * P_W'(e2z_reg);
            mx1_reg <= P_W'(e1z_reg) * P_W'(e2y_reg);
            my0_reg <= P_W'(e1z_reg) * P_W'(e2x_reg);
            my1_reg <= P_W'(e1x_reg) * P_W'(e2z_reg);
            mz0_reg <= P_W'(e1x_reg) * P_W'(e2y_reg);
            mz1_reg <= P_W'(e1y_reg) * P_W'(e2x_reg);
        end
    end

    // Stage 3: cross product components.
    logic                  s3_valid_reg;
    logic signed [R_W-1:0] rx_reg, ry_reg, rz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rx_reg <= R_W'(mx0_reg) - R_W'(mx1_reg);
            ry_reg <= R_W'(my0_reg) - R_W'(my1_reg);
            rz_reg <= R_W'(mz0_reg) - R_W'(mz1_reg);
        end
    end

    // Divider preparation: magnitudes, quotient signs and the zero-area flag.
    logic [R_W-1:0] mag_x, mag_y, mag_z;

    assign mag_x = rx_reg[R_W-1] ? R_W'(-rx_reg) : R_W'(rx_reg);
    assign mag_y = ry_reg[R_W-1] ? R_W'(-ry_reg) : R_W'(ry_reg);
    assign mag_z = rz_reg[R_W-1] ? R_W'(-rz_reg) : R_W'(rz_reg);

    // Divider stages; stage k holds k resolved quotient bits.
    logic           dv_valid_reg [0:N];
    logic [A_W-1:0] acc_u_reg    [0:N];
    logic [A_W-1:0] acc_v_reg    [0:N];
    logic [R_W-1:0] dvs_reg      [0:N];
    logic           neg_u_reg    [0:N];
    logic           neg_v_reg    [0:N];
    logic           degen_reg    [0:N];
    logic [A_W-1:0] acc_u_next   [1:N];
    logic [A_W-1:0] acc_v_next   [1:N];

    always_comb
    begin
        for (int k = 1; k <= N; k++)
        begin
            acc_u_next[k] = div_step(acc_u_reg[k-1], dvs_reg[k-1]);
            acc_v_next[k] = div_step(acc_v_reg[k-1], dvs_reg[k-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
            begin
                dv_valid_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            dv_valid_reg[0] <= s3_valid_reg;
            for (int k = 1; k <= N; k++)
            begin
                dv_valid_reg[k] <= dv_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            acc_u_reg[0] <= A_W'(mag_x) << WEIGHT_FRAC_BITS;
            acc_v_reg[0] <= A_W'(mag_y) << WEIGHT_FRAC_BITS;
            dvs_reg[0]   <= (rz_reg == '0) ? R_W'(1) : mag_z;
            neg_u_reg[0] <= rx_reg[R_W-1] ^ rz_reg[R_W-1];
            neg_v_reg[0] <= ry_reg[R_W-1] ^ rz_reg[R_W-1];
            degen_reg[0] <= (rz_reg == '0);
            for (int k = 1; k <= N; k++)
            begin
                acc_u_reg[k] <= acc_u_next[k];
                acc_v_reg[k] <= acc_v_next[k];
                dvs_reg[k]   <= dvs_reg[k-1];
                neg_u_reg[k] <= neg_u_reg[k-1];
                neg_v_reg[k] <= neg_v_reg[k-1];
                degen_reg[k] <= degen_reg[k-1];
            end
        end
    end

    // Output stage: restore signs, form 1-u-v and saturate.
    logic signed [S_W-1:0] q_u, q_v, u_s, v_s, w_a;
    weight_t               weight_a_reg, weight_b_reg, weight_c_reg;
    logic                  degenerate_reg, out_valid_reg;

    assign q_u = $signed(S_W'(acc_u_reg[N][N-1:0]));
    assign q_v = $signed(S_W'(acc_v_reg[N][N-1:0]));
    assign u_s = neg_u_reg[N] ? -q_u : q_u;
    assign v_s = neg_v_reg[N] ? -q_v : q_v;
    assign w_a = ONE - u_s - v_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= dv_valid_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            degenerate_reg <= degen_reg[N];
            if (degen_reg[N])
            begin
                weight_a_reg <= '0;
                weight_b_reg <= '0;
                weight_c_reg <= '0;
            end
            else
            begin
                weight_a_reg <= sat_w(w_a);
                weight_b_reg <= sat_w(v_s);
                weight_c_reg <= sat_w(u_s);
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign weight_a   = weight_a_reg;
    assign weight_b   = weight_b_reg;
    assign weight_c   = weight_c_reg;
    assign degenerate = degenerate_reg;

endmodule

@@ verif/tb_triangle_barycentric_weights_top.sv @@
// Testbench for the barycentric weight pipeline: drives random and directed triangles,
// predicts the weights and checks every result in order. Depends on tbw_pkg and the RTL.
`timescale 1ns / 100ps

module tb_triangle_barycentric_weights_top;
    import tbw_pkg::*;

    localparam int NUM_RANDOM = 1330;
    localparam int ONE_Q16    = 1 << 16;
    localparam longint W_MAX  = 64'sd8388607;
    localparam longint W_MIN  = -64'sd8388608;

    typedef struct {
        corner_t ax, ay, bx, by, cx, cy;
        pixel_t  px, py;
    } tri_req_t;

    typedef struct {
        weight_t wa, wb, wc;
        logic    degen;
    } weights_t;

    // Holds the weights still owed by the block and compares each result.
    class weight_scoreboard;
        weights_t owed[$];
        int       errors;
        int       checked;
        int       degen_seen;

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        function longint clamp24(longint x);
            if (x > W_MAX) return W_MAX;
            if (x < W_MIN) return W_MIN;
            return x;
        endfunction

        // Exact cross product, then truncating divisions in Q16.
        function weights_t barycentric_weights(tri_req_t r);
            weights_t w;
            longint ax, ay, px, py, e1x, e1y, e1z, e2x, e2y, e2z;
            longint rx, ry, rz, u, v;
            ax = longint'(r.ax);
            ay = longint'(r.ay);
            px = longint'(r.px) << 4;
            py = longint'(r.py) << 4;
            e1x = longint'(r.cx) - ax;
            e1y = longint'(r.bx) - ax;
            e1z = ax - px;
            e2x = longint'(r.cy) - ay;
            e2y = longint'(r.by) - ay;
            e2z = ay - py;
            rx = e1y * e2z - e1z * e2y;
            ry = e1z * e2x - e1x * e2z;
            rz = e1x * e2y - e1y * e2x;
            if (rz == 0)
            begin
                w.wa = '0;
                w.wb = '0;
                w.wc = '0;
                w.degen = 1'b1;
            end
            else
            begin
                u = (rx * ONE_Q16) / rz;
                v = (ry * ONE_Q16) / rz;
                w.wa = weight_t'(clamp24(ONE_Q16 - u - v));
                w.wb = weight_t'(clamp24(v));
                w.wc = weight_t'(clamp24(u));
                w.degen = 1'b0;
            end
            return w;
        endfunction

        function void note_request(tri_req_t r);
            owed.push_back(barycentric_weights(r));
        endfunction

        task check_result(weights_t got);
            weights_t exp_w;
            if (owed.size() == 0)
            begin
                report("result with no request outstanding");
                return;
            end
            exp_w = owed.pop_front();
            checked++;
            if (got.degen) degen_seen++;
            if (got.wa !== exp_w.wa)
                report($sformatf("weight_a got %0d exp %0d", got.wa, exp_w.wa));
            if (got.wb !== exp_w.wb)
                report($sformatf("weight_b got %0d exp %0d", got.wb, exp_w.wb));
            if (got.wc !== exp_w.wc)
                report($sformatf("weight_c got %0d exp %0d", got.wc, exp_w.wc));
            if (got.degen !== exp_w.degen)
                report($sformatf("degenerate got %0b exp %0b", got.degen, exp_w.degen));
        endtask
    endclass

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    corner_t corner_a_x, corner_a_y, corner_b_x, corner_b_y, corner_c_x, corner_c_y;
    pixel_t  pixel_x, pixel_y;
    logic    out_valid;
    logic    out_ready;
    weight_t weight_a, weight_b, weight_c;
    logic    degenerate;

    weight_scoreboard sb;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_request;

    triangle_barycentric_weights_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .corner_a_x(corner_a_x), .corner_a_y(corner_a_y),
        .corner_b_x(corner_b_x), .corner_b_y(corner_b_y),
        .corner_c_x(corner_c_x), .corner_c_y(corner_c_y),
        .pixel_x(pixel_x), .pixel_y(pixel_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c),
        .degenerate(degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #3000000;
        $display("FAIL triangle_barycentric_weights_top");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        weights_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.wa = weight_a;
            got.wb = weight_b;
            got.wc = weight_c;
            got.degen = degenerate;
            sb.check_result(got);
        end
    end

    // Offers one request after an optional idle gap and waits for acceptance.
    // Each cycle before the offer is left idle with the phase's idle chance.
    task send_request(tri_req_t r);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        corner_a_x <= r.ax;
        corner_a_y <= r.ay;
        corner_b_x <= r.bx;
        corner_b_y <= r.by;
        corner_c_x <= r.cx;
        corner_c_y <= r.cy;
        pixel_x <= r.px;
        pixel_y <= r.py;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_request(r);
    endtask

    function tri_req_t make_req(int ax, int ay, int bx, int by, int cx, int cy,
                                int px, int py);
        tri_req_t r;
        r.ax = corner_t'(ax);
        r.ay = corner_t'(ay);
        r.bx = corner_t'(bx);
        r.by = corner_t'(by);
        r.cx = corner_t'(cx);
        r.cy = corner_t'(cy);
        r.px = pixel_t'(px);
        r.py = pixel_t'(py);
        return r;
    endfunction

    // Random triangle: fully random, local to the pixel, or collapsed to a line.
    function tri_req_t random_req();
        tri_req_t r;
        int kind, px, py, base_x, base_y, dx, dy;
        kind = $urandom_range(0, 9);
        px = $urandom_range(0, 4095);
        py = $urandom_range(0, 4095);
        if (kind < 3)
            r = make_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, px, py);
        else if (kind < 8)
        begin
            px = $urandom_range(0, 2000);
            py = $urandom_range(0, 2000);
            base_x = px * 16;
            base_y = py * 16;
            r = make_req(base_x + $urandom_range(0, 1600) - 800,
                         base_y + $urandom_range(0, 1600) - 800,
                         base_x + $urandom_range(0, 1600) - 800,
                         base_y + $urandom_range(0, 1600) - 800,
                         base_x + $urandom_range(0, 1600) - 800,
                         base_y + $urandom_range(0, 1600) - 800, px, py);
        end
        else
        begin
            // Three collinear corners give a zero-area triangle.
            base_x = $urandom_range(0, 20000) - 10000;
            base_y = $urandom_range(0, 20000) - 10000;
            dx = $urandom_range(0, 200) - 100;
            dy = $urandom_range(0, 200) - 100;
            r = make_req(base_x, base_y, base_x + dx, base_y + dy,
                         base_x + 3 * dx, base_y + 3 * dy, px, py);
        end
        return r;
    endfunction

    initial
    begin
        tri_req_t directed[$];
        int phase;
        sb = new();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_request = 0;
        in_valid = 1'b0;
        corner_a_x = '0;
        corner_a_y = '0;
        corner_b_x = '0;
        corner_b_y = '0;
        corner_c_x = '0;
        corner_c_y = '0;
        pixel_x = '0;
        pixel_y = '0;
        rst_n = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, zero area, a unit triangle and saturating weights.
        directed.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_req(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0));
        directed.push_back(make_req(32767, 32767, 32767, 32767, 32767, 32767, 4095, 4095));
        directed.push_back(make_req(-32768, -32768, 32767, -32768, -32768, 32767, 4095, 4095));
        directed.push_back(make_req(32767, 32767, -32768, 32767, 32767, -32768, 0, 0));
        directed.push_back(make_req(-32768, 32767, 32767, 32767, -32768, -32768, 4095, 0));
        directed.push_back(make_req(0, 0, 16, 0, 0, 16, 0, 0));
        directed.push_back(make_req(0, 0, 160, 0, 0, 160, 5, 5));
        directed.push_back(make_req(0, 0, 1, 0, 0, 1, 4095, 4095));
        directed.push_back(make_req(0, 0, 1, 0, 0, 1, 0, 4095));
        directed.push_back(make_req(0, 0, -1, 0, 0, 1, 2047, 0));
        directed.push_back(make_req(100, 100, 200, 200, 300, 300, 10, 10));
        directed.push_back(make_req(16, 16, 16, 16, 800, 32, 1, 1));
        directed.push_back(make_req(32767, -32768, -32768, 32767, 0, 0, 2048, 2048));
        directed.push_back(make_req(-16, -16, 16, -16, 0, 16, 0, 0));
        foreach (directed[i]) send_request(directed[i]);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            phase = i / (NUM_RANDOM / 4);
            sender_idle_pct    = (phase == 1) ? 60 : (phase == 3) ? 22 : 0;
            receiver_stall_pct = (phase == 2) ? 60 : (phase == 3) ? 22 : 0;
            // Long receiver hold-off so the pipeline fills and stalls its input.
            if (i == 150)
                hold_request = 200;
            // Pause the sender until everything outstanding has come back.
            if (i == 700)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (sb.owed.size() != 0) @(posedge clk);
            end
            send_request(random_req());
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.owed.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Checked %0d weight results (%0d zero-area) over idle and stall phases,",
                 sb.checked, sb.degen_seen);
        $display("including a long result hold-off and a full drain mid-run.");
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("PASS triangle_barycentric_weights_top");
        else
            $display("FAIL triangle_barycentric_weights_top");
        $finish;
    end

endmodule
